[src/psr_pkg.sv]
// Shared types and constants for the per-stream sequence reorder block.
// No dependencies; every other file of the block but psr_fifo imports this package.
package psr_pkg;

	localparam int STREAM_W    = 2;
	localparam int SEQ_W       = 32;
	localparam int DATA_W      = 32;
	localparam int MAX_STREAMS = 1 << STREAM_W;
	localparam int QUEUE_DEPTH = 4;

	// An accepted input word on its way from the front to the back.
	typedef struct packed {
		logic [STREAM_W-1:0] stream;
		logic [SEQ_W-1:0]    seq;
		logic [DATA_W-1:0]   payload;
	} psr_item_t;

	// A released word waiting in the result queue.
	typedef struct packed {
		logic [STREAM_W-1:0] stream;
		logic [SEQ_W-1:0]    seq;
		logic [DATA_W-1:0]   payload;
		logic                last;
	} psr_rel_t;

endpackage

[src/psr_fifo.sv]
// Small synchronous first-in first-out queue with an occupancy count.
// Depends on nothing; used between front and back and for the results.
module psr_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty,
	output logic [$clog2(DEPTH):0] level
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LW = $clog2(DEPTH) + 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [LW-1:0]    level_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (level_q == LW'(DEPTH));
	assign empty   = (level_q == '0);
	assign level   = level_q;
	assign rd_data = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				level_q <= level_q + 1'b1;
			end else if (do_pop && !do_push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

endmodule

[src/psr_front.sv]
// Input stage: registers each word, drops words of streams that do not exist
// and trims the payload. Depends on psr_pkg; feeds the queue toward psr_back.
module psr_front
	import psr_pkg::*;
#(
	parameter int NUM_STREAMS   = 4,
	parameter int PAYLOAD_WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [STREAM_W-1:0] stream,
	input  logic [SEQ_W-1:0]    seq,
	input  logic [DATA_W-1:0]   payload,
	input  logic                q_full,
	output logic                q_push,
	output psr_item_t           q_data
);

	localparam int SW = (PAYLOAD_WIDTH < DATA_W) ? PAYLOAD_WIDTH : DATA_W;

	logic      vld_s1;
	logic      keep_s1;
	psr_item_t item_s1;
	logic      drain;
	logic      take;

	// A dropped word leaves at once; a kept one waits for room in the queue.
	assign drain  = vld_s1 && (!keep_s1 || !q_full);
	assign full   = vld_s1 && !drain;
	assign take   = push && !full;
	assign q_push = vld_s1 && keep_s1 && !q_full;
	assign q_data = item_s1;

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.stream  <= stream;
			item_s1.seq     <= seq;
			item_s1.payload <= DATA_W'(payload[SW-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			keep_s1 <= 1'b0;
		end else if (take) begin
			vld_s1  <= 1'b1;
			keep_s1 <= (32'(stream) < 32'(NUM_STREAMS));
		end else if (drain) begin
			vld_s1  <= 1'b0;
		end
	end

endmodule

[src/psr_back.sv]
// Reorder engine: window check, slot store and in-order release walk.
// Depends on psr_pkg; reads the item queue and writes the result queue.
module psr_back
	import psr_pkg::*;
#(
	parameter int NUM_STREAMS   = 4,
	parameter int WINDOW        = 16,
	parameter int PAYLOAD_WIDTH = 32,
	parameter int OUT_DEPTH     = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_empty,
	input  psr_item_t                   q_data,
	output logic                        q_pop,
	input  logic [$clog2(OUT_DEPTH):0]  o_level,
	output logic                        o_push,
	output psr_rel_t                    o_data
);

	localparam int NSE = (NUM_STREAMS < MAX_STREAMS) ? NUM_STREAMS : MAX_STREAMS;
	localparam int SB  = (NSE > 1) ? $clog2(NSE) : 1;
	localparam int WB  = $clog2(WINDOW);
	localparam int SW  = (PAYLOAD_WIDTH < DATA_W) ? PAYLOAD_WIDTH : DATA_W;
	localparam int AW  = SB + WB;
	localparam int LW  = $clog2(OUT_DEPTH) + 1;

	typedef enum logic {ST_IDLE, ST_WALK} st_t;

	st_t                 st_q;
	logic [SB-1:0]       cur_q;
	logic [SEQ_W-1:0]    exp_q   [NSE];
	logic [WB-1:0]       head_q  [NSE];
	logic [WINDOW-1:0]   valid_q [NSE];
	logic [SW-1:0]       mem     [2**AW];
	logic [SW-1:0]       rdata_q;
	logic                vld_s2;
	logic [STREAM_W-1:0] stream_s2;
	logic [SEQ_W-1:0]    seq_s2;
	logic                last_s2;

	logic [SB-1:0]       q_sidx;
	logic [SEQ_W-1:0]    gap;
	logic                in_win;
	logic [WB:0]         sum;
	logic [WB:0]         slot;
	logic                store;
	logic [AW-1:0]       wr_addr;
	logic [WB-1:0]       h;
	logic [WB-1:0]       nxt;
	logic [WINDOW-1:0]   cur_valid;
	logic                hit;
	logic                last;
	logic                credit;
	logic                issue;
	logic [AW-1:0]       rd_addr;

	// Window check and slot of the word at the head of the item queue.
	assign q_sidx  = q_data.stream[SB-1:0];
	assign gap     = q_data.seq - exp_q[q_sidx];
	assign in_win  = (gap < SEQ_W'(WINDOW));
	assign sum     = {1'b0, head_q[q_sidx]} + gap[WB:0];
	assign slot    = (sum >= (WB+1)'(WINDOW)) ? sum - (WB+1)'(WINDOW) : sum;
	assign wr_addr = {q_sidx, slot[WB-1:0]};
	assign q_pop   = (st_q == ST_IDLE) && !q_empty;
	assign store   = q_pop && in_win;

	// Release walk: the head slot goes out when filled; the run ends when the
	// slot after it is empty.
	assign h         = head_q[cur_q];
	assign nxt       = (h == WB'(WINDOW - 1)) ? '0 : h + 1'b1;
	assign cur_valid = valid_q[cur_q];
	assign hit       = cur_valid[h];
	assign last      = !cur_valid[nxt];
	assign credit    = (o_level + LW'(vld_s2)) < LW'(OUT_DEPTH);
	assign issue     = (st_q == ST_WALK) && hit && credit;
	assign rd_addr   = {cur_q, h};

	assign o_push         = vld_s2;
	assign o_data.stream  = stream_s2;
	assign o_data.seq     = seq_s2;
	assign o_data.payload = DATA_W'(rdata_q);
	assign o_data.last    = last_s2;

	always_ff @(posedge clk) begin
		if (store) begin
			mem[wr_addr] <= q_data.payload[SW-1:0];
		end
		if (issue) begin
			rdata_q   <= mem[rd_addr];
			stream_s2 <= STREAM_W'(cur_q);
			seq_s2    <= exp_q[cur_q];
			last_s2   <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			cur_q  <= '0;
			vld_s2 <= 1'b0;
			for (int s = 0; s < NSE; s++) begin
				exp_q[s]   <= '0;
				head_q[s]  <= '0;
				valid_q[s] <= '0;
			end
		end else begin
			vld_s2 <= issue;
			unique case (st_q)
				ST_IDLE: begin
					if (q_pop) begin
						cur_q <= q_sidx;
						if (in_win) begin
							valid_q[q_sidx][slot[WB-1:0]] <= 1'b1;
							st_q <= ST_WALK;
						end
					end
				end
				ST_WALK: begin
					if (!hit) begin
						st_q <= ST_IDLE;
					end else if (credit) begin
						valid_q[cur_q][h] <= 1'b0;
						exp_q[cur_q]      <= exp_q[cur_q] + 1'b1;
						head_q[cur_q]     <= nxt;
						if (last) begin
							st_q <= ST_IDLE;
						end
					end
				end
			endcase
		end
	end

	a_credit: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> (o_level < LW'(OUT_DEPTH)))
		else $error("result queue written while full");

	a_store_walk: assert property (@(posedge clk) disable iff (!arst_n)
		store |=> (st_q == ST_WALK))
		else $error("stored word not followed by a release walk");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(issue && last) |=> (st_q == ST_IDLE && vld_s2))
		else $error("walk did not end after the last word of a run");

endmodule

[src/per_stream_sequence_reorder.sv]
// Top level of the per-stream sequence reorder buffer.
// Depends on psr_pkg, psr_fifo, psr_front and psr_back.
//
// Channel   Direction  Handshake           Fields
// input     in         push / full         stream, seq, payload
// result    out        pop / empty         out_stream, out_seq, out_payload, run_last
//
// A word that enters is held in the front register, then waits in a
// four-entry queue. In its idle state the back engine does the window check
// and slot store of each word; a word inside the window starts a release
// walk that sends out one word of the run per step, and a word outside the
// window starts none. The next word is not taken until the walk ends.
// Released words pass a registered memory read and land in a four-entry
// result queue. Reset clears every stream's expected sequence, head and
// slot valid bits at once; no clearing pass is needed. A full result queue
// stalls only the release walk; the input side keeps taking words until the
// item queue fills.
module per_stream_sequence_reorder
	import psr_pkg::*;
#(
	parameter int NUM_STREAMS   = 4,
	parameter int WINDOW        = 16,
	parameter int PAYLOAD_WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [STREAM_W-1:0] stream,
	input  logic [SEQ_W-1:0]    seq,
	input  logic [DATA_W-1:0]   payload,
	output logic                empty,
	input  logic                pop,
	output logic [STREAM_W-1:0] out_stream,
	output logic [SEQ_W-1:0]    out_seq,
	output logic [DATA_W-1:0]   out_payload,
	output logic                run_last
);

	localparam int LW = $clog2(QUEUE_DEPTH) + 1;

	// Front to item queue.
	logic      mid_push;
	logic      mid_full;
	psr_item_t mid_wr;

	// Item queue to back.
	logic      mid_pop;
	logic      mid_empty;
	psr_item_t mid_rd;

	// Back to result queue.
	logic          res_push;
	psr_rel_t      res_wr;
	psr_rel_t      res_rd;
	logic [LW-1:0] res_level;

	psr_front #(
		.NUM_STREAMS  (NUM_STREAMS),
		.PAYLOAD_WIDTH(PAYLOAD_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.stream   (stream),
		.seq      (seq),
		.payload  (payload),
		.q_full   (mid_full),
		.q_push   (mid_push),
		.q_data   (mid_wr)
	);

	// Decouples the input side from the release walk.
	psr_fifo #(
		.WIDTH($bits(psr_item_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_item_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.wr_data(mid_wr),
		.full   (mid_full),
		.pop    (mid_pop),
		.rd_data(mid_rd),
		.empty  (mid_empty),
		.level  ()
	);

	psr_back #(
		.NUM_STREAMS  (NUM_STREAMS),
		.WINDOW       (WINDOW),
		.PAYLOAD_WIDTH(PAYLOAD_WIDTH),
		.OUT_DEPTH    (QUEUE_DEPTH)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_empty(mid_empty),
		.q_data (mid_rd),
		.q_pop  (mid_pop),
		.o_level(res_level),
		.o_push (res_push),
		.o_data (res_wr)
	);

	// Released words wait here until the consumer pops them; the back engine
	// reserves room before it reads a slot, so this queue never overflows.
	psr_fifo #(
		.WIDTH($bits(psr_rel_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wr_data(res_wr),
		.full   (),
		.pop    (pop),
		.rd_data(res_rd),
		.empty  (empty),
		.level  (res_level)
	);

	assign out_stream  = res_rd.stream;
	assign out_seq     = res_rd.seq;
	assign out_payload = res_rd.payload;
	assign run_last    = res_rd.last;

endmodule

[tb/testbench.sv]
// Self-checking testbench for the per-stream sequence reorder block.
// Depends on psr_pkg and per_stream_sequence_reorder.
// Drives shuffled per-stream runs plus noise, and checks every released word.
`timescale 1ns / 100ps

module testbench;
	import psr_pkg::*;

	localparam int NUM_STREAMS   = 4;
	localparam int WINDOW        = 16;
	localparam int PAYLOAD_WIDTH = 32;

	// Rough count of well-formed words in the random part.
	localparam int RANDOM_WORDS = 380;
	// Cycles in which neither side moves a word before the run is declared hung.
	localparam int QUIET_LIMIT  = 2000;
	// Cycles allowed after the last expected word for a dropped word to settle.
	localparam int SETTLE_CYCLES = 64;
	// Both sides run without idling inside this cycle window.
	localparam int STEADY_FROM  = 300;
	localparam int STEADY_TO    = 700;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                push = 1'b0;
	logic                full;
	logic [STREAM_W-1:0] stream = '0;
	logic [SEQ_W-1:0]    seq = '0;
	logic [DATA_W-1:0]   payload = '0;
	logic                empty;
	logic                pop = 1'b0;
	logic [STREAM_W-1:0] out_stream;
	logic [SEQ_W-1:0]    out_seq;
	logic [DATA_W-1:0]   out_payload;
	logic                run_last;

	// Words waiting to be offered, and released words still owed by the block.
	psr_item_t send_words [$];
	psr_rel_t  due_words [$];
	psr_item_t next_word;
	psr_rel_t  got_word;

	// Shadow of each stream's reorder window.
	logic [SEQ_W-1:0]  next_seq [NUM_STREAMS];
	logic [WINDOW-1:0] held_mask [NUM_STREAMS];
	logic [DATA_W-1:0] held_word [NUM_STREAMS][WINDOW];
	int unsigned       head_slot [NUM_STREAMS];

	int fault_count = 0;
	int quiet_cycles = 0;
	int cycle_no = 0;

	per_stream_sequence_reorder #(
		.NUM_STREAMS  (NUM_STREAMS),
		.WINDOW       (WINDOW),
		.PAYLOAD_WIDTH(PAYLOAD_WIDTH)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.stream     (stream),
		.seq        (seq),
		.payload    (payload),
		.empty      (empty),
		.pop        (pop),
		.out_stream (out_stream),
		.out_seq    (out_seq),
		.out_payload(out_payload),
		.run_last   (run_last)
	);

	always #5 clk = ~clk;

	// Stores an accepted word in its stream's window and queues every word of
	// the in-order run that it completes. The distance from the expected
	// sequence is taken modulo 2^32, so sequences already released land far
	// outside the window and are dropped along with those too far ahead.
	task automatic absorb_word(input psr_item_t w);
		logic [SEQ_W-1:0] gap;
		int unsigned      slot;
		psr_rel_t         r;
		gap = w.seq - next_seq[w.stream];
		if (gap >= WINDOW)
			return;
		slot = (head_slot[w.stream] + int'(gap)) % WINDOW;
		held_word[w.stream][slot] = w.payload;
		held_mask[w.stream][slot] = 1'b1;
		while (held_mask[w.stream][head_slot[w.stream]]) begin
			r.stream  = w.stream;
			r.seq     = next_seq[w.stream];
			r.payload = held_word[w.stream][head_slot[w.stream]];
			held_mask[w.stream][head_slot[w.stream]] = 1'b0;
			next_seq[w.stream]  = next_seq[w.stream] + 1;
			head_slot[w.stream] = (head_slot[w.stream] + 1) % WINDOW;
			// The run ends where the next slot is still empty.
			r.last = !held_mask[w.stream][head_slot[w.stream]];
			due_words.push_back(r);
		end
	endtask

	task automatic add_word(input int s, input logic [SEQ_W-1:0] q,
			input logic [DATA_W-1:0] d);
		psr_item_t w;
		w.stream  = s[STREAM_W-1:0];
		w.seq     = q;
		w.payload = d;
		send_words.push_back(w);
	endtask

	// About one cycle in five is an idle one, except inside the steady window.
	function automatic logic rest_now();
		if (cycle_no >= STEADY_FROM && cycle_no < STEADY_TO)
			return 1'b0;
		return $urandom_range(99, 0) < 20;
	endfunction

	// Input side: offers the next queued word, holds it while full is high,
	// and runs the prediction at the edge where the word is accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push      <= 1'b0;
			stream    <= '0;
			seq       <= '0;
			payload   <= '0;
		end else begin
			if (push && !full)
				absorb_word(psr_item_t'{stream, seq, payload});
			if (!push || !full) begin
				if (send_words.size() != 0 && !rest_now()) begin
					next_word = send_words.pop_front();
					push      <= 1'b1;
					stream    <= next_word.stream;
					seq       <= next_word.seq;
					payload   <= next_word.payload;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// Result side: every popped word must match the oldest expected word.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				got_word = psr_rel_t'{out_stream, out_seq, out_payload, run_last};
				if (due_words.size() == 0) begin
					$display("%0t: unexpected word: stream %0d seq %h payload %h last %b",
						$time, out_stream, out_seq, out_payload, run_last);
					fault_count++;
				end else begin
					if (got_word !== due_words[0]) begin
						$display("%0t: mismatch: expected stream %0d seq %h payload %h last %b",
							$time, due_words[0].stream, due_words[0].seq,
							due_words[0].payload, due_words[0].last);
						$display("%0t:           actual   stream %0d seq %h payload %h last %b",
							$time, out_stream, out_seq, out_payload, run_last);
						fault_count++;
					end
					void'(due_words.pop_front());
				end
			end
			pop <= !rest_now();
		end
	end

	// Counts cycles in which neither side moves a word; the main block ends
	// the run once this reaches the limit.
	always @(posedge clk) begin
		cycle_no <= cycle_no + 1;
		if (!arst_n || (push && !full) || (pop && !empty))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		logic [SEQ_W-1:0] gen_next [NUM_STREAMS];
		psr_item_t        lane [NUM_STREAMS][$];
		psr_item_t        tmp;
		logic [SEQ_W-1:0] nseq;
		int               s, k, j, pick, roll, well_formed;
		logic             timed_out;

		for (s = 0; s < NUM_STREAMS; s++) begin
			next_seq[s]  = '0;
			held_mask[s] = '0;
			head_slot[s] = 0;
		end

		// Directed part. A single in-order word with an all-ones payload.
		add_word(0, 0, 32'hFFFF_FFFF);
		// One word early, then the gap filler: a run of two, zero payload.
		add_word(1, 1, 32'h0000_0000);
		add_word(1, 0, 32'h1234_5678);
		// A duplicate overwrites the stored word before the run is released.
		add_word(2, 3, 32'hAAAA_AAAA);
		add_word(2, 3, 32'h5555_5555);
		add_word(2, 2, 32'h0F0F_0F0F);
		add_word(2, 1, 32'hF0F0_F0F0);
		add_word(2, 0, 32'h8000_0001);
		// Already released, one past the window, far behind, and the last slot.
		add_word(2, 0, 32'hDEAD_BEEF);
		add_word(2, 4 + WINDOW, 32'hDEAD_BEEF);
		add_word(2, 32'hFFFF_FFFF, 32'hDEAD_BEEF);
		add_word(2, 4 + WINDOW - 1, 32'h7FFF_FFFE);
		// A whole window filled out of order and released in one run.
		for (j = 1; j < WINDOW; j++)
			add_word(3, j, $urandom);
		add_word(3, 0, $urandom);

		gen_next[0] = 1;
		gen_next[1] = 2;
		gen_next[2] = 4;
		gen_next[3] = WINDOW;

		// Random part: each round builds a shuffled run per stream, sometimes
		// with a duplicate, and merges the runs with a little noise between.
		well_formed = 0;
		while (well_formed < RANDOM_WORDS) begin
			for (s = 0; s < NUM_STREAMS; s++) begin
				k = $urandom_range(WINDOW, 1);
				for (j = 0; j < k; j++) begin
					tmp.stream  = s[STREAM_W-1:0];
					tmp.seq     = gen_next[s] + j;
					tmp.payload = $urandom;
					lane[s].push_back(tmp);
				end
				if ($urandom_range(5, 0) == 0) begin
					tmp = lane[s][$urandom_range(k - 1, 0)];
					tmp.payload = $urandom;
					lane[s].push_back(tmp);
				end
				for (j = lane[s].size() - 1; j > 0; j--) begin
					pick = $urandom_range(j, 0);
					tmp = lane[s][j];
					lane[s][j] = lane[s][pick];
					lane[s][pick] = tmp;
				end
				gen_next[s] = gen_next[s] + k;
			end
			while (lane[0].size() + lane[1].size() + lane[2].size() + lane[3].size() > 0)
			begin
				do
					s = $urandom_range(NUM_STREAMS - 1, 0);
				while (lane[s].size() == 0);
				send_words.push_back(lane[s].pop_front());
				well_formed++;
				roll = $urandom_range(99, 0);
				s = $urandom_range(NUM_STREAMS - 1, 0);
				if (roll < 4) begin
					nseq = $urandom;
					add_word(s, nseq, $urandom);
				end else if (roll < 8) begin
					nseq = gen_next[s] + WINDOW + $urandom_range(15, 0);
					add_word(s, nseq, $urandom);
				end else if (roll < 12) begin
					nseq = gen_next[s] - 1 - $urandom_range(40, 0);
					add_word(s, nseq, $urandom);
				end
			end
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Sampling on the falling edge keeps clear of the edge-time updates.
		timed_out = 1'b0;
		do begin
			@(negedge clk);
			if (quiet_cycles >= QUIET_LIMIT)
				timed_out = 1'b1;
		end while (!timed_out && !(send_words.size() == 0 && !push && due_words.size() == 0));

		// Let any trailing dropped words drain; a stray result still fails.
		if (!timed_out)
			repeat (SETTLE_CYCLES) @(negedge clk);
		if (due_words.size() != 0) begin
			$display("%0t: %0d expected words never arrived", $time, due_words.size());
			fault_count++;
		end
		if (!timed_out && fault_count == 0)
			$display("** per_stream_sequence_reorder: PASSED **");
		else
			$display("** per_stream_sequence_reorder: FAILED **");
		$finish;
	end

endmodule

[per_stream_sequence_reorder.f]
src/psr_pkg.sv
src/psr_fifo.sv
src/psr_front.sv
src/psr_back.sv
src/per_stream_sequence_reorder.sv
tb/testbench.sv
